[design/lsa_pkg.sv]
// ----------------------------------------------------------------------------
// lsa_pkg
// Shared types and constants of the LIFO stack allocator.
// ----------------------------------------------------------------------------
package lsa_pkg;

    localparam int SIZE_W    = 16;   // request size
    localparam int ADDR_W    = 32;   // byte address
    localparam int STATUS_W  = 3;
    localparam int BYTES_W   = 23;   // current / peak totals
    localparam int OFFS_W    = 17;   // region size, offset, aligned size
    localparam int MAXE_W    = 7;    // max_entries register
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;

    localparam logic [BYTES_W-1:0] BYTES_MAX = '1;

    // register map, index = paddr[3:2]
    localparam logic [1:0] REG_STACK_SIZE  = 2'd0;
    localparam logic [1:0] REG_MAX_ENTRIES = 2'd1;
    localparam logic [1:0] REG_STACK_BASE  = 2'd2;

    localparam logic [OFFS_W-1:0]  RST_STACK_SIZE  = 17'd65536;
    localparam logic [MAXE_W-1:0]  RST_MAX_ENTRIES = 7'd64;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_STACK_GRANT = 3'd0,
        ST_HEAP_GRANT  = 3'd1,
        ST_TABLE_FULL  = 3'd2,
        ST_FREED       = 3'd3,
        ST_FREE_REJECT = 3'd4
    } t_status;

    typedef struct packed {
        logic [OFFS_W-1:0] stack_size;
        logic [MAXE_W-1:0] max_entries;
        logic [ADDR_W-1:0] stack_base;
    } t_cfg;

    // controller -> datapath
    typedef struct packed {
        logic load;    // latch request
        logic mul;     // reciprocal multiply
        logic scale;   // quotient * alignment
        logic rd;      // read top entry
        logic exec;    // update state, load result
    } t_cmd;

    typedef struct packed {
        logic              heap;
        logic [OFFS_W-1:0] size;
        logic [ADDR_W-1:0] addr;
    } t_entry;

endpackage

[design/lsa_req_if.sv]
// ----------------------------------------------------------------------------
// lsa_req_if
// Request channel: allocate or free.
// ----------------------------------------------------------------------------
interface lsa_req_if;
    import lsa_pkg::*;

    logic              valid;
    logic              ready;
    logic              kind;
    logic [SIZE_W-1:0] size;
    logic [ADDR_W-1:0] addr;

    modport source (output valid, kind, size, addr, input ready);
    modport sink   (input valid, kind, size, addr, output ready);
endinterface

[design/lsa_rsp_if.sv]
// ----------------------------------------------------------------------------
// lsa_rsp_if
// Result channel: granted address, status and byte totals.
// ----------------------------------------------------------------------------
interface lsa_rsp_if;
    import lsa_pkg::*;

    logic                valid;
    logic                ready;
    logic [ADDR_W-1:0]   addr_out;
    logic [STATUS_W-1:0] status;
    logic [BYTES_W-1:0]  current_bytes;
    logic [BYTES_W-1:0]  peak_bytes;

    modport source (output valid, addr_out, status, current_bytes, peak_bytes, input ready);
    modport sink   (input valid, addr_out, status, current_bytes, peak_bytes, output ready);
endinterface

[design/lsa_regs.sv]
// ----------------------------------------------------------------------------
// lsa_regs
// APB configuration registers: stack_size, max_entries, stack_base.
// ----------------------------------------------------------------------------
module lsa_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lsa_pkg::PADDR_W-1:0]   paddr,
    input  logic [lsa_pkg::PDATA_W-1:0]   pwdata,
    output logic [lsa_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    output lsa_pkg::t_cfg                 o_cfg
);
    import lsa_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.stack_size  <= RST_STACK_SIZE;
            r_cfg.max_entries <= RST_MAX_ENTRIES;
            r_cfg.stack_base  <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_STACK_SIZE:  r_cfg.stack_size  <= pwdata[OFFS_W-1:0];
                REG_MAX_ENTRIES: r_cfg.max_entries <= pwdata[MAXE_W-1:0];
                REG_STACK_BASE:  r_cfg.stack_base  <= pwdata[ADDR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_STACK_SIZE:  prdata = PDATA_W'(r_cfg.stack_size);
            REG_MAX_ENTRIES: prdata = PDATA_W'(r_cfg.max_entries);
            REG_STACK_BASE:  prdata = r_cfg.stack_base;
            default:         prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

[design/lsa_ctrl.sv]
// ----------------------------------------------------------------------------
// lsa_ctrl
// Request sequencer: accept, align (two steps), read top entry, execute.
// ----------------------------------------------------------------------------
module lsa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    output logic          o_rsp_valid,
    input  logic          i_rsp_ready,
    output lsa_pkg::t_cmd o_cmd
);
    import lsa_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_MUL   = 5'b00010,
        S_SCALE = 5'b00100,
        S_READ  = 5'b01000,
        S_EXEC  = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   slot_free;
    logic   accept;

    // result slot frees when empty or being taken this cycle
    assign slot_free = !r_out_valid || i_rsp_ready;
    assign accept    = (r_state == S_IDLE) && i_req_valid;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_req_valid) n_state = S_MUL;
            S_MUL:   n_state = S_SCALE;
            S_SCALE: n_state = S_READ;
            S_READ:  n_state = S_EXEC;
            S_EXEC:  if (slot_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.load  = accept;
        o_cmd.mul   = (r_state == S_MUL);
        o_cmd.scale = (r_state == S_SCALE);
        o_cmd.rd    = (r_state == S_READ);
        o_cmd.exec  = (r_state == S_EXEC) && slot_free;
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.exec) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_rsp_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_out_valid;

`ifndef SYNTHESIS
    a_exec_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec |-> (!r_out_valid || i_rsp_ready))
        else $error("result loaded over an untaken result");

    a_exec_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec |=> o_rsp_valid)
        else $error("executed request produced no result");

    a_accept_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_MUL) && !o_req_ready)
        else $error("accepted request did not start");
`endif

endmodule

[design/lsa_dp.sv]
// ----------------------------------------------------------------------------
// lsa_dp
// Datapath: size alignment, entry table, offset and byte counters, result.
// ----------------------------------------------------------------------------
module lsa_dp #(
    parameter int MAX_ENTRIES = 64,
    parameter int STACK_BYTES = 65536,
    parameter int ALIGN_BYTES = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  lsa_pkg::t_cmd                  i_cmd,
    input  lsa_pkg::t_cfg                  i_cfg,
    input  logic                           i_kind,
    input  logic [lsa_pkg::SIZE_W-1:0]     i_size,
    input  logic [lsa_pkg::ADDR_W-1:0]     i_addr,
    output logic [lsa_pkg::ADDR_W-1:0]     o_addr_out,
    output logic [lsa_pkg::STATUS_W-1:0]   o_status,
    output logic [lsa_pkg::BYTES_W-1:0]    o_current_bytes,
    output logic [lsa_pkg::BYTES_W-1:0]    o_peak_bytes
);
    import lsa_pkg::*;

    localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
    localparam int IDX_W   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CMP_W   = (CNT_W > MAXE_W) ? CNT_W : MAXE_W;
    // round-up division by ALIGN_BYTES as an exact reciprocal multiply
    localparam int ALIGN_L = $clog2(ALIGN_BYTES);
    localparam int SHIFT   = OFFS_W + ALIGN_L;
    localparam int RCP_W   = OFFS_W + 1;
    localparam int PROD_W  = SHIFT + OFFS_W;
    localparam logic [RCP_W-1:0] RECIP =
        RCP_W'(((64'd1 << SHIFT) + 64'(ALIGN_BYTES) - 64'd1) / 64'(ALIGN_BYTES));
    localparam logic [OFFS_W-1:0] LIM_CAP =
        (STACK_BYTES > 2**OFFS_W - 1) ? {OFFS_W{1'b1}} : OFFS_W'(STACK_BYTES);
    localparam logic [CMP_W-1:0] ENT_CAP = CMP_W'(MAX_ENTRIES);

    t_entry mem [MAX_ENTRIES];

    // request
    logic              r_kind;
    logic [SIZE_W-1:0] r_size;
    logic [ADDR_W-1:0] r_addr;
    logic [OFFS_W-1:0] r_quot;
    logic [OFFS_W-1:0] r_aligned;
    t_entry            r_top;

    // allocator state
    logic [OFFS_W-1:0]  r_offset, n_offset;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [BYTES_W-1:0] r_total, n_total;
    logic [BYTES_W-1:0] r_peak, n_peak;

    // result
    logic [ADDR_W-1:0]  r_out_addr, n_out_addr;
    t_status            r_out_status, n_out_status;

    logic [OFFS_W-1:0]  round_in;
    logic [PROD_W-1:0]  prod;
    logic [CNT_W-1:0]   cnt_m1;
    logic [CMP_W-1:0]   ent_limit;
    logic [CMP_W-1:0]   cnt_ext;
    logic [OFFS_W-1:0]  region;
    logic [OFFS_W:0]    end_offs;
    logic               fits;
    logic               full;
    logic [BYTES_W:0]   sum_total;
    logic               wr_en;
    t_entry             wr_entry;

    assign round_in = {1'b0, r_size} + OFFS_W'(ALIGN_BYTES - 1);
    assign prod     = PROD_W'(round_in) * PROD_W'(RECIP);
    assign cnt_m1   = r_count - CNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_kind;
            r_size <= i_size;
            r_addr <= i_addr;
        end
        if (i_cmd.mul) begin
            r_quot <= prod[SHIFT +: OFFS_W];
        end
        if (i_cmd.scale) begin
            r_aligned <= OFFS_W'(r_quot * OFFS_W'(ALIGN_BYTES));
        end
    end

    // entry table: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_count[IDX_W-1:0]] <= wr_entry;
        end
        if (i_cmd.rd) begin
            r_top <= mem[cnt_m1[IDX_W-1:0]];
        end
    end

    always_comb begin
        cnt_ext   = CMP_W'(r_count);
        ent_limit = (CMP_W'(i_cfg.max_entries) < ENT_CAP) ? CMP_W'(i_cfg.max_entries)
                                                          : ENT_CAP;
        full      = (cnt_ext >= ent_limit);
        region    = (i_cfg.stack_size < LIM_CAP) ? i_cfg.stack_size : LIM_CAP;
        end_offs  = {1'b0, r_offset} + {1'b0, r_aligned};
        fits      = (end_offs <= {1'b0, region});
        sum_total = {1'b0, r_total} + (BYTES_W + 1)'(r_aligned);
    end

    always_comb begin
        n_offset      = r_offset;
        n_count       = r_count;
        n_total       = r_total;
        n_peak        = r_peak;
        n_out_addr    = '0;
        n_out_status  = ST_FREE_REJECT;
        wr_en         = 1'b0;
        wr_entry.heap = !fits;
        wr_entry.size = r_aligned;
        wr_entry.addr = fits ? (i_cfg.stack_base + ADDR_W'(r_offset)) : r_addr;

        if (r_kind == KIND_ALLOC) begin
            if (full) begin
                n_out_status = ST_TABLE_FULL;
            end else begin
                wr_en        = i_cmd.exec;
                n_out_addr   = wr_entry.addr;
                n_out_status = fits ? ST_STACK_GRANT : ST_HEAP_GRANT;
                if (fits) begin
                    n_offset = end_offs[OFFS_W-1:0];
                end
                n_total = sum_total[BYTES_W] ? BYTES_MAX : sum_total[BYTES_W-1:0];
                if (r_peak < n_total) begin
                    n_peak = n_total;
                end
                n_count = r_count + CNT_W'(1);
            end
        end else begin
            if (r_count != '0 && r_top.addr == r_addr) begin
                n_out_status = ST_FREED;
                if (!r_top.heap) begin
                    n_offset = (r_offset >= r_top.size) ? r_offset - r_top.size : '0;
                end
                n_total = (r_total >= BYTES_W'(r_top.size)) ? r_total - BYTES_W'(r_top.size)
                                                            : '0;
                n_count = cnt_m1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
            r_count  <= '0;
            r_total  <= '0;
            r_peak   <= '0;
        end else if (i_cmd.exec) begin
            r_offset <= n_offset;
            r_count  <= n_count;
            r_total  <= n_total;
            r_peak   <= n_peak;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_out_addr   <= n_out_addr;
            r_out_status <= n_out_status;
        end
    end

    assign o_addr_out      = r_out_addr;
    assign o_status        = r_out_status;
    assign o_current_bytes = r_total;
    assign o_peak_bytes    = r_peak;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMP_W'(r_count) <= ENT_CAP)
        else $error("entry count beyond table depth");

    a_peak_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_peak >= r_total)
        else $error("peak below current total");

    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && r_kind == KIND_ALLOC && full)
        |=> $stable(r_count) && $stable(r_offset) && $stable(r_total))
        else $error("state changed on table-full request");

    a_offset_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_offset <= LIM_CAP)
        else $error("stack offset past region cap");
`endif

endmodule

[design/lifo_stack_allocator_unit.sv]
// ----------------------------------------------------------------------------
// lifo_stack_allocator_unit
// LIFO stack allocator over a fixed region with heap-address fallback.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one request: kind (0 allocate, 1 free), size, addr.
//   o_rsp returns exactly one result per request: addr_out, status,
//   current_bytes and peak_bytes, in request order.
//   The APB port holds stack_size, max_entries and stack_base; write them
//   only while no request is in flight.
// Timing:
//   A request is taken only when the unit is idle and then runs through
//   accept, reciprocal multiply, scale by alignment, table read, execute.
//   The result is valid the cycle after execute; a new request can be taken
//   in that same cycle but not earlier; the step sequence is set by
//   the alignment multiplier and the registered read of the entry table.
//   The result sits in an output register; a new request is accepted while
//   it waits, and execute holds until the receiver has taken the old one.
// Reset:
//   Synchronous, active low. Clears offset, entry count and byte totals and
//   loads the register defaults. The entry table is not cleared.
// ----------------------------------------------------------------------------
module lifo_stack_allocator_unit #(
    parameter int MAX_ENTRIES = 64,
    parameter int STACK_BYTES = 65536,
    parameter int ALIGN_BYTES = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    lsa_req_if.sink                      i_req,
    lsa_rsp_if.source                    o_rsp,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lsa_pkg::PADDR_W-1:0]  paddr,
    input  logic [lsa_pkg::PDATA_W-1:0]  pwdata,
    output logic [lsa_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);
    import lsa_pkg::*;

    t_cfg cfg;
    t_cmd cmd;

    lsa_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    lsa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .o_cmd       (cmd)
    );

    lsa_dp #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .STACK_BYTES (STACK_BYTES),
        .ALIGN_BYTES (ALIGN_BYTES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_cfg           (cfg),
        .i_kind          (i_req.kind),
        .i_size          (i_req.size),
        .i_addr          (i_req.addr),
        .o_addr_out      (o_rsp.addr_out),
        .o_status        (o_rsp.status),
        .o_current_bytes (o_rsp.current_bytes),
        .o_peak_bytes    (o_rsp.peak_bytes)
    );

endmodule
